@@ rtl/core/cle_pkg.sv @@
// Shared characters and result descriptor type for the console line editor.
package cle_pkg;

   localparam logic [7:0] CH_CTRL_C = 8'h03;
   localparam logic [7:0] CH_BELL   = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DEL    = 8'h7f;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // All the response side needs for one item's results, save the read data.
   typedef struct packed {
      logic [1:0] count;
      logic       echo;
      logic [7:0] ch0;
      logic [7:0] ch1;
      logic [7:0] ch2;
      logic       done;
      logic       rep;
      logic       ovf;
      logic       is_read;
      logic       rd_hit;
      logic [7:0] length;
   } echo_desc_type;

endpackage

@@ rtl/core/console_line_editor.sv @@
// Top level of the console line editor: line state, buffer and response path.
//
//   channel   direction   payload
//   req_*     in          tuser: func; tdata: key, read_index
//   rsp_*     out         tuser: echo_valid; tlast: last; tdata: echo_char, line_done,
//                         line_length, reprompt, overflow, read_data
//
// An item is decoded and the line state and buffer updated at its transfer edge.
// Its results then leave one per cycle from the response register while rsp_tready is
// held high; an item has one to three results, or none, in which case it loads nothing.
// The next request is taken in the cycle its predecessor's last result transfers.
// Reset clears the fill count, the completion flag and the response register's valid and beat state.
// A stalled response holds the request side until its final result is taken.
module console_line_editor
   import cle_pkg::*;
#(
   parameter int LINE_BYTES = 160
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key [7:0], read_index [15:8]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // echo_char [7:0], line_done [8], line_length [16:9],
                                    // reprompt [17], overflow [18], read_data [26:19]
   output logic        rsp_tuser,   // echo_valid
   output logic        rsp_tlast    // last
);

   localparam int FW = $clog2(LINE_BYTES + 1);
   localparam int AW = $clog2(LINE_BYTES);

   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic          complete_ff;
   logic          complete_in;
   logic          accept;
   logic          finishing;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   echo_desc_type desc;

   assign req_tready = !rsp_tvalid || finishing;
   assign accept     = req_tvalid && req_tready;

   cle_key_decode #(.LINE_BYTES(LINE_BYTES)) u_decode (
      .func          (req_tuser),
      .key           (req_tdata[7:0]),
      .read_index    (req_tdata[15:8]),
      .fill          (fill_ff),
      .complete      (complete_ff),
      .fill_next     (fill_in),
      .complete_next (complete_in),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .desc          (desc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         complete_ff <= 1'b0;
      end else if (accept) begin
         fill_ff     <= fill_in;
         complete_ff <= complete_in;
      end
   end

   cle_line_store #(.DEPTH(LINE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept && rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cle_rsp_seq u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && (desc.count != 2'd0)),
      .desc       (desc),
      .rd_data    (rd_data),
      .finishing  (finishing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(LINE_BYTES))
      else $error("fill count beyond buffer size");

   a_complete_nonempty: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> (fill_ff != '0))
      else $error("completed line with no characters");

   a_read_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("read response not a single result");

   a_accept_on_finish: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_tvalid) |-> (rsp_tready && rsp_tlast))
      else $error("request taken while results are pending");

   a_done_not_reprompt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[17]))
      else $error("line both completed and discarded");

endmodule

@@ rtl/core/cle_key_decode.sv @@
// Key mapping, line state update and result descriptor for one request.
module cle_key_decode
   import cle_pkg::*;
#(
   parameter int LINE_BYTES = 160,
   localparam int FW = $clog2(LINE_BYTES + 1),
   localparam int AW = $clog2(LINE_BYTES)
) (
   input  logic          func,
   input  logic [7:0]    key,
   input  logic [7:0]    read_index,
   input  logic [FW-1:0] fill,
   input  logic          complete,
   output logic [FW-1:0] fill_next,
   output logic          complete_next,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   output echo_desc_type desc
);

   logic [7:0]    k;
   logic [FW-1:0] fill_eff;
   logic          full;
   logic          discard;
   logic          allowed;
   logic [15:0]   ridx_wide;
   logic [15:0]   len_wide;

   always_comb begin
      k = key;
      if (key == CH_CR) k = CH_LF;
      if (key == CH_DEL) k = CH_BS;
   end

   assign fill_eff = complete ? '0 : fill;
   assign full     = (fill_eff == FW'(LINE_BYTES - 1));
   assign discard  = (k == CH_CTRL_C) || (full && (k != CH_LF));
   assign allowed  = (k inside {["0":"9"], ["A":"Z"], ["a":"z"], CH_SPACE, CH_BS, CH_LF,
                                "?", 8'h5f, "=", "!", "."});

   assign ridx_wide = {8'h00, read_index};
   assign rd_addr   = ridx_wide[AW-1:0];
   assign wr_addr   = fill_eff[AW-1:0];
   assign wr_data   = k;

   always_comb begin
      fill_next     = fill;
      complete_next = complete;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      desc          = '0;
      if (func == FUNC_READ) begin
         rd_en        = 1'b1;
         desc.count   = 2'd1;
         desc.is_read = 1'b1;
         desc.rd_hit  = (ridx_wide < 16'(fill)) && (ridx_wide < 16'(LINE_BYTES));
      end else begin
         // A key after a completed line always begins a fresh one.
         complete_next = 1'b0;
         fill_next     = fill_eff;
         desc.echo     = 1'b1;
         if (discard) begin
            fill_next = '0;
            desc.rep  = 1'b1;
            desc.ovf  = (fill_eff >= FW'(LINE_BYTES - 1));
            desc.ch0  = CH_CR;
            desc.ch1  = CH_LF;
            desc.ch2  = CH_BELL;
            desc.count = desc.ovf ? 2'd3 : 2'd2;
         end else if (!allowed) begin
            desc.count = 2'd0;
         end else if (k == CH_BS) begin
            if (fill_eff == '0) begin
               desc.count = 2'd1;
               desc.ch0   = CH_BELL;
            end else begin
               fill_next  = fill_eff - FW'(1);
               desc.count = 2'd3;
               desc.ch0   = CH_BS;
               desc.ch1   = CH_SPACE;
               desc.ch2   = CH_BS;
            end
         end else begin
            if (fill_eff < FW'(LINE_BYTES)) begin
               wr_en     = 1'b1;
               fill_next = fill_eff + FW'(1);
            end
            if (k == CH_LF) begin
               complete_next = 1'b1;
               desc.done     = 1'b1;
               desc.count    = 2'd2;
               desc.ch0      = CH_CR;
               desc.ch1      = CH_LF;
            end else begin
               desc.count = 2'd1;
               desc.ch0   = k;
            end
         end
      end
      len_wide    = 16'(fill_next);
      desc.length = len_wide[7:0];
   end

endmodule

@@ rtl/core/cle_line_store.sv @@
// Line buffer memory with one write port and one registered read port.
module cle_line_store #(
   parameter int DEPTH = 160,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cle_rsp_seq.sv @@
// Response register that plays out up to three results of one item.
module cle_rsp_seq
   import cle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  echo_desc_type desc,
   input  logic [7:0]    rd_data,
   output logic          finishing,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   echo_desc_type desc_ff;
   logic          busy_ff;
   logic          busy_in;
   logic [1:0]    beat_ff;
   logic [1:0]    beat_in;
   logic [7:0]    ch;
   logic [7:0]    rdata;
   logic          last;

   assign last      = (beat_ff == desc_ff.count - 2'd1);
   assign finishing = busy_ff && rsp_tready && last;

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (busy_ff && rsp_tready) begin
         beat_in = beat_ff + 2'd1;
         if (last) busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         beat_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
      if (load) desc_ff <= desc;
   end

   always_comb begin
      case (beat_ff)
         2'd0:    ch = desc_ff.ch0;
         2'd1:    ch = desc_ff.ch1;
         default: ch = desc_ff.ch2;
      endcase
   end

   assign rdata      = (desc_ff.is_read && desc_ff.rd_hit) ? rd_data : 8'h00;
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = last;
   assign rsp_tuser  = desc_ff.echo;
   assign rsp_tdata  = {5'd0, rdata, desc_ff.ovf, desc_ff.rep, desc_ff.length,
                        desc_ff.done, desc_ff.echo ? ch : 8'h00};

endmodule
